/* rtl/rrgd_pkg.sv */
package rrgd_pkg;

  // default geometry of the attached display
  localparam int DEF_SCREEN_WIDTH      = 240;
  localparam int DEF_SCREEN_HEIGHT     = 320;
  localparam int DEF_MAX_COLUMN_PIXELS = 240;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLUMN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LIMIT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_COLORS = 3'd7;

  // arithmetic unit sizes
  localparam int DIV_W       = 26;  // |(e2 - s2) * dx| stays below 2^26
  localparam int DEN_W       = 10;
  localparam int SQRT_W      = 18;
  localparam int ROOT_W      = SQRT_W / 2;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [9:0] column_offset;
    logic [9:0] row_offset;
  } in_t;

  typedef struct packed {
    logic        drawn;
    logic [9:0]  scr_x;
    logic [9:0]  scr_y;
    logic [15:0] pixel_color;
  } out_t;

  typedef struct packed {
    logic signed [10:0] origin_x;
    logic signed [10:0] origin_y;
    logic [9:0]         rect_width;
    logic [9:0]         rect_height;
    logic [8:0]         corner_radius;
    logic signed [10:0] first_column;
    logic signed [10:0] column_limit;
    logic [31:0]        gradient_colors;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic       valid;
    logic       drawn;
    logic [9:0] sx;
    logic [9:0] sy;
    logic [9:0] dx;
  } qent_t;

  // 8x8 ordered dither, row-major
  localparam logic [5:0] DITHER_TAB [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  function automatic logic [5:0] dither(logic [2:0] row, logic [2:0] col);
    return DITHER_TAB[{row, col}];
  endfunction

  function automatic logic [7:0] exp5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] exp6(logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // flat colour when both ends match or the rectangle is one column wide
  function automatic logic is_solid(cfg_t c);
    return (c.gradient_colors[31:16] == c.gradient_colors[15:0]) ||
           (c.rect_width == 10'd1);
  endfunction

endpackage

/* rtl/rounded_rect_gradient_dither_top.sv */
// rounded rectangle pixel generator with dithered gradient colour
//
// input channel: one pixel position (column and row offset inside the rectangle)
// per beat on in_data, taken at a clock edge with start high and busy low.
// result channel: one beat per input, out_valid high for exactly one cycle with
// drawn, screen coordinates and RGB565 colour on out_data; undrawn pixels give
// all-zero fields. the receiver cannot stall, and the block never needs it to.
// configuration: cfg_we, cfg_index and cfg_wdata write one register per edge;
// write only while no pixel is in flight.
// throughput: one pixel per clock, sustained. a pixel passes the front (corner root
// 9 stages), the queue and the back (26-stage divider then 9-stage root per
// channel); all fully pipelined, the queue drains every cycle, busy stays low.
// reset: synchronous, active low; clears the configuration registers to zero,
// drops every beat in flight, and out_valid is low from the next cycle on.
module rounded_rect_gradient_dither_top #(
  parameter int SCREEN_WIDTH      = rrgd_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT     = rrgd_pkg::DEF_SCREEN_HEIGHT,
  parameter int MAX_COLUMN_PIXELS = rrgd_pkg::DEF_MAX_COLUMN_PIXELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  rrgd_pkg::in_t                  in_data,
  output logic                           out_valid,
  output rrgd_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [rrgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrgd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rrgd_pkg::cfg_t  cfg_r;
  rrgd_pkg::qent_t push;
  rrgd_pkg::qent_t pop_data;
  logic            full;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrgd_pkg::REG_ORIGIN_X:        cfg_r.origin_x        <= cfg_wdata[10:0];
        rrgd_pkg::REG_ORIGIN_Y:        cfg_r.origin_y        <= cfg_wdata[10:0];
        rrgd_pkg::REG_RECT_WIDTH:      cfg_r.rect_width      <= cfg_wdata[9:0];
        rrgd_pkg::REG_RECT_HEIGHT:     cfg_r.rect_height     <= cfg_wdata[9:0];
        rrgd_pkg::REG_CORNER_RADIUS:   cfg_r.corner_radius   <= cfg_wdata[8:0];
        rrgd_pkg::REG_FIRST_COLUMN:    cfg_r.first_column    <= cfg_wdata[10:0];
        rrgd_pkg::REG_COLUMN_LIMIT:    cfg_r.column_limit    <= cfg_wdata[10:0];
        rrgd_pkg::REG_GRADIENT_COLORS: cfg_r.gradient_colors <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign busy = full;

  rrgd_front #(
    .SCREEN_WIDTH      (SCREEN_WIDTH),
    .SCREEN_HEIGHT     (SCREEN_HEIGHT),
    .MAX_COLUMN_PIXELS (MAX_COLUMN_PIXELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (start && !busy),
    .in_data  (in_data),
    .push     (push)
  );

  rrgd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop_data (pop_data),
    .full     (full)
  );

  rrgd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* rtl/rrgd_isqrt.sv */
module rrgd_isqrt (
  input  logic                       clk,
  input  logic [rrgd_pkg::SQRT_W-1:0] v,
  output logic [rrgd_pkg::ROOT_W-1:0] root
);

  localparam int SW = rrgd_pkg::SQRT_W;
  localparam int RW = rrgd_pkg::ROOT_W;

  logic [RW+1:0] rem_s  [1:RW];
  logic [RW-1:0] root_s [1:RW];
  logic [SW-1:0] src_s  [1:RW];

  // one root bit per stage, two radicand bits shifted in each time
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rem_i;
    logic [RW-1:0] root_i;
    logic [SW-1:0] src_i;
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign src_i  = v;
    end else begin : g_next
      assign rem_i  = rem_s[k];
      assign root_i = root_s[k];
      assign src_i  = src_s[k];
    end

    assign cur   = {rem_i, src_i[SW-1:SW-2]};
    assign trial = {2'b00, root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (cur >= trial) begin
        rem_s[k+1]  <= (RW+2)'(cur - trial);
        root_s[k+1] <= {root_i[RW-2:0], 1'b1};
      end else begin
        rem_s[k+1]  <= cur[RW+1:0];
        root_s[k+1] <= {root_i[RW-2:0], 1'b0};
      end
      src_s[k+1] <= {src_i[SW-3:0], 2'b00};
    end
  end

  assign root = root_s[RW];

endmodule

/* rtl/rrgd_div.sv */
module rrgd_div (
  input  logic                       clk,
  input  logic [rrgd_pkg::DIV_W-1:0] num,
  input  logic [rrgd_pkg::DEN_W-1:0] den,
  output logic [rrgd_pkg::DIV_W-1:0] quo
);

  localparam int DW = rrgd_pkg::DIV_W;
  localparam int NW = rrgd_pkg::DEN_W;

  logic [NW-1:0] rem_s [1:DW];
  logic [DW-1:0] src_s [1:DW];
  logic [DW-1:0] quo_s [1:DW];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [NW-1:0] rem_i;
    logic [DW-1:0] src_i;
    logic [DW-1:0] quo_i;
    logic [NW:0]   cur;
    logic          fits;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign src_i = num;
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_s[k];
      assign src_i = src_s[k];
      assign quo_i = quo_s[k];
    end

    assign cur  = {rem_i, src_i[DW-1]};
    assign fits = cur >= {1'b0, den};

    always_ff @(posedge clk) begin
      rem_s[k+1] <= fits ? NW'(cur - {1'b0, den}) : cur[NW-1:0];
      src_s[k+1] <= {src_i[DW-2:0], 1'b0};
      quo_s[k+1] <= {quo_i[DW-2:0], fits};
    end
  end

  assign quo = quo_s[DW];

endmodule

/* rtl/rrgd_front.sv */
module rrgd_front #(
  parameter int SCREEN_WIDTH      = rrgd_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT     = rrgd_pkg::DEF_SCREEN_HEIGHT,
  parameter int MAX_COLUMN_PIXELS = rrgd_pkg::DEF_MAX_COLUMN_PIXELS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rrgd_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  rrgd_pkg::in_t  in_data,
  output rrgd_pkg::qent_t push
);

  localparam int RW = rrgd_pkg::ROOT_W;

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic       mid;
    logic [8:0] rad;
    logic [9:0] dx;
    logic [9:0] dy;
  } fstage_t;

  logic                  a_valid_r;
  logic [9:0]            a_dx_r;
  logic [9:0]            a_dy_r;
  fstage_t               b_r;
  logic [8:0]            b_cdx_r;
  fstage_t               c_r;
  logic [rrgd_pkg::SQRT_W-1:0] c_inside_r;
  fstage_t               side_r [1:RW];
  logic [RW-1:0]         root;
  rrgd_pkg::qent_t       push_r;

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_dx_r <= in_data.column_offset;
    a_dy_r <= in_data.row_offset;
  end

  // column range, radius clamp and corner distance
  logic signed [11:0] c0, c1, c1_raw, w_s, dx_s;
  logic [8:0]         r1, r2;
  logic [9:0]         rr, w_minus_r, cdx;
  logic               range_ok, mid;

  always_comb begin
    w_s    = $signed({2'b00, cfg.rect_width});
    dx_s   = $signed({2'b00, a_dx_r});
    c0     = cfg.first_column[10] ? 12'sd0 : $signed({cfg.first_column[10], cfg.first_column});
    c1_raw = $signed({cfg.column_limit[10], cfg.column_limit});
    c1     = (c1_raw > w_s) ? w_s : c1_raw;
    range_ok = (cfg.rect_width != 10'd0) && (cfg.rect_height != 10'd0) &&
               (c0 < c1) && (dx_s >= c0) && (dx_s < c1);
    r1 = (cfg.corner_radius > cfg.rect_width[9:1]) ? cfg.rect_width[9:1] : cfg.corner_radius;
    r2 = (r1 > cfg.rect_height[9:1]) ? cfg.rect_height[9:1] : r1;
    rr        = {1'b0, r2};
    w_minus_r = cfg.rect_width - rr;
    mid = (r2 == 9'd0) || ((a_dx_r >= rr) && (a_dx_r < w_minus_r));
    cdx = (a_dx_r < rr) ? (rr - 10'd1 - a_dx_r) : (a_dx_r - w_minus_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else begin
      b_r.valid <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_r.ok   <= range_ok;
    b_r.mid  <= mid;
    b_r.rad  <= r2 - 9'd1;
    b_r.dx   <= a_dx_r;
    b_r.dy   <= a_dy_r;
    b_cdx_r  <= cdx[8:0];
  end

  // squared distance left under the arc
  logic [rrgd_pkg::SQRT_W-1:0] rad_sq, cdx_sq;

  assign rad_sq = {9'd0, b_r.rad} * {9'd0, b_r.rad};
  assign cdx_sq = {9'd0, b_cdx_r} * {9'd0, b_cdx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else begin
      c_r.valid <= b_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    {c_r.ok, c_r.mid, c_r.rad, c_r.dx, c_r.dy} <= {b_r.ok, b_r.mid, b_r.rad, b_r.dx, b_r.dy};
    c_inside_r <= rad_sq - cdx_sq;
  end

  rrgd_isqrt u_isqrt (
    .clk  (clk),
    .v    (c_inside_r),
    .root (root)
  );

  // carry pixel info alongside the root pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= RW; k++) begin
        side_r[k] <= '0;
      end
    end else begin
      side_r[1] <= c_r;
      for (int k = 2; k <= RW; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // column extent, row test and screen clip
  fstage_t            s;
  logic [9:0]         inset;
  logic signed [11:0] colh, cap, maxc, sx, sy;
  logic [11:0]        row_end;
  logic               solid, row_ok, on_screen, drawn;

  always_comb begin
    s       = side_r[RW];
    solid   = rrgd_pkg::is_solid(cfg);
    inset   = s.mid ? 10'd0 : ({1'b0, s.rad} - {1'b0, root});
    colh    = $signed({2'b00, cfg.rect_height}) - $signed({1'b0, inset, 1'b0});
    maxc    = $signed(12'(MAX_COLUMN_PIXELS));
    cap     = (!solid && (colh > maxc)) ? maxc : colh;
    row_end = {2'b00, inset} + $unsigned(cap);
    row_ok  = (colh > 12'sd0) && (s.dy >= inset) && ({2'b00, s.dy} < row_end);
    sx = $signed({cfg.origin_x[10], cfg.origin_x}) + $signed({2'b00, s.dx});
    sy = $signed({cfg.origin_y[10], cfg.origin_y}) + $signed({2'b00, s.dy});
    on_screen = !sx[11] && (sx < $signed(12'(SCREEN_WIDTH))) &&
                !sy[11] && (sy < $signed(12'(SCREEN_HEIGHT)));
    drawn = s.ok && row_ok && on_screen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_r.valid <= 1'b0;
    end else begin
      push_r.valid <= s.valid;
    end
  end

  always_ff @(posedge clk) begin
    push_r.drawn <= drawn;
    push_r.sx    <= sx[9:0];
    push_r.sy    <= sy[9:0];
    push_r.dx    <= s.dx;
  end

  assign push = push_r;

endmodule

/* rtl/rrgd_queue.sv */
module rrgd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  rrgd_pkg::qent_t push,
  output rrgd_pkg::qent_t pop_data,
  output logic            full
);

  localparam int DEPTH = rrgd_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  rrgd_pkg::qent_t mem [DEPTH];
  logic [AW-1:0]   wr_r, rd_r;
  logic [AW:0]     cnt_r;
  rrgd_pkg::qent_t pop_r;
  logic            pop;

  assign pop = cnt_r != '0;

  // storage write
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_r] <= push;
    end
  end

  // registered head read
  always_ff @(posedge clk) begin
    pop_r.drawn <= mem[rd_r].drawn;
    pop_r.sx    <= mem[rd_r].sx;
    pop_r.sy    <= mem[rd_r].sy;
    pop_r.dx    <= mem[rd_r].dx;
  end

  // pointers and fill level, head drains every cycle it holds a beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r        <= '0;
      rd_r        <= '0;
      cnt_r       <= '0;
      pop_r.valid <= 1'b0;
    end else begin
      if (push.valid) begin
        wr_r <= wr_r + AW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + AW'(1);
      end
      cnt_r       <= cnt_r + (AW+1)'(push.valid) - (AW+1)'(pop);
      pop_r.valid <= pop;
    end
  end

  assign pop_data = pop_r;
  assign full     = cnt_r >= (AW+1)'(DEPTH - 1);

endmodule

/* rtl/rrgd_back.sv */
module rrgd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rrgd_pkg::cfg_t  cfg,
  input  rrgd_pkg::qent_t pop_data,
  output logic            out_valid,
  output rrgd_pkg::out_t  out_data
);

  localparam int DW        = rrgd_pkg::DIV_W;
  localparam int RW        = rrgd_pkg::ROOT_W;
  localparam int SIDE_LAST = 1 + DW + 1 + RW;

  logic [15:0] scol, ecol;
  logic [7:0]  s8 [3];
  logic [7:0]  e8 [3];
  logic [15:0] s2_r   [3];
  logic [15:0] absd_r [3];
  logic        neg_r  [3];
  logic [DW-1:0] mag_r [3];
  logic [DW-1:0] quo   [3];
  logic [rrgd_pkg::SQRT_W-1:0] v_r [3];
  logic [RW-1:0] root [3];
  rrgd_pkg::qent_t side_r [0:SIDE_LAST];
  logic            out_valid_r;
  rrgd_pkg::out_t  out_data_r;

  // channel endpoints expanded to 8 bits
  always_comb begin
    scol  = cfg.gradient_colors[31:16];
    ecol  = cfg.gradient_colors[15:0];
    s8[0] = rrgd_pkg::exp5(scol[15:11]);
    s8[1] = rrgd_pkg::exp6(scol[10:5]);
    s8[2] = rrgd_pkg::exp5(scol[4:0]);
    e8[0] = rrgd_pkg::exp5(ecol[15:11]);
    e8[1] = rrgd_pkg::exp6(ecol[10:5]);
    e8[2] = rrgd_pkg::exp5(ecol[4:0]);
  end

  // squared endpoints and their spread, steady while pixels flow
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [15:0] s2, e2;
      s2 = {8'd0, s8[ch]} * {8'd0, s8[ch]};
      e2 = {8'd0, e8[ch]} * {8'd0, e8[ch]};
      s2_r[ch]   <= s2;
      neg_r[ch]  <= e2 < s2;
      absd_r[ch] <= (e2 >= s2) ? (e2 - s2) : (s2 - e2);
    end
  end

  // beat info travels beside the arithmetic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SIDE_LAST; k++) begin
        side_r[k] <= '0;
      end
    end else begin
      side_r[0] <= pop_data;
      for (int k = 1; k <= SIDE_LAST; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // spread times column
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      mag_r[ch] <= {10'd0, absd_r[ch]} * {16'd0, side_r[0].dx};
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic signed [rrgd_pkg::SQRT_W-1:0] vs;

    rrgd_div u_div (
      .clk (clk),
      .num (mag_r[ch]),
      .den (cfg.rect_width - 10'd1),
      .quo (quo[ch])
    );

    // quotient truncated toward zero, applied with the spread's sign
    always_comb begin
      if (neg_r[ch]) begin
        vs = $signed({2'b00, s2_r[ch]}) - $signed({2'b00, quo[ch][15:0]});
      end else begin
        vs = $signed({2'b00, s2_r[ch]}) + $signed({2'b00, quo[ch][15:0]});
      end
    end

    always_ff @(posedge clk) begin
      v_r[ch] <= vs[rrgd_pkg::SQRT_W-1] ? '0 : $unsigned(vs);
    end

    rrgd_isqrt u_isqrt (
      .clk  (clk),
      .v    (v_r[ch]),
      .root (root[ch])
    );
  end

  // dither, saturate and pack
  rrgd_pkg::qent_t s;
  logic [5:0]      d;
  logic [8:0]      rv, gv, bv;
  logic [7:0]      r8, g8, b8;
  logic [15:0]     color;

  always_comb begin
    s  = side_r[SIDE_LAST];
    d  = rrgd_pkg::dither(s.sy[2:0], s.sx[2:0]);
    rv = {1'b0, root[0][7:0]} + {6'd0, d[5:3]};
    gv = {1'b0, root[1][7:0]} + {7'd0, d[5:4]};
    bv = {1'b0, root[2][7:0]} + {6'd0, d[5:3]};
    r8 = rv[8] ? 8'hFF : rv[7:0];
    g8 = gv[8] ? 8'hFF : gv[7:0];
    b8 = bv[8] ? 8'hFF : bv[7:0];
    if (rrgd_pkg::is_solid(cfg)) begin
      color = scol;
    end else begin
      color = {r8[7:3], g8[7:2], b8[7:3]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.drawn       <= s.drawn;
    out_data_r.scr_x       <= s.drawn ? s.sx : 10'd0;
    out_data_r.scr_y       <= s.drawn ? s.sy : 10'd0;
    out_data_r.pixel_color <= s.drawn ? color : 16'd0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/rrgd_checker.sv */
module rrgd_checker #(
  parameter int SCREEN_WIDTH  = rrgd_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = rrgd_pkg::DEF_SCREEN_HEIGHT
) (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input rrgd_pkg::out_t out_data
);

  // an undrawn beat carries no coordinates or colour
  a_undrawn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.drawn |->
      out_data.scr_x == 10'd0 && out_data.scr_y == 10'd0 &&
      out_data.pixel_color == 16'd0)
    else $error("undrawn beat with nonzero fields");

  // a drawn pixel lies on the screen
  a_drawn_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.drawn |->
      out_data.scr_x < 10'(SCREEN_WIDTH) && out_data.scr_y < 10'(SCREEN_HEIGHT))
    else $error("drawn pixel off screen");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("beat or busy survived reset");

  // the back end keeps pace, so input is never held off
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("input held off");

endmodule

bind rounded_rect_gradient_dither_top rrgd_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_rrgd_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int SCR_W = 240;
  localparam int SCR_H = 320;
  localparam int MAX_COL = 240;
  localparam int LATENCY = 54;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rrgd_pkg::in_t in_data;
  logic out_valid;
  rrgd_pkg::out_t out_data;
  logic cfg_we;
  logic [rrgd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rrgd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rounded_rect_gradient_dither_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the registers
  int sh_ox, sh_oy, sh_w, sh_h, sh_r, sh_c0, sh_c1;
  logic [31:0] sh_colors;

  rrgd_pkg::out_t pixel_q[$];
  int mismatches;
  int cycles;
  bit quiet;

  // directed table: column, row, whether expected is given, expected pixel
  typedef struct {
    int col;
    int row;
    bit fixed;
    rrgd_pkg::out_t res;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sx11(logic [31:0] v);
    int t;
    t = int'(v[10:0]);
    return (t >= 1024) ? t - 2048 : t;
  endfunction

  function automatic int root_floor(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return int'(r);
  endfunction

  function automatic int channel_mix(int s, int e, int dx, int stp);
    int s2, e2, num, q, v;
    s2 = s * s;
    e2 = e * e;
    num = (e2 - s2) * dx;
    q = (num < 0) ? -((-num) / stp) : num / stp;
    v = s2 + q;
    if (v < 0) v = 0;
    return root_floor(v);
  endfunction

  function automatic int exp5_of(logic [4:0] v);
    return int'({v, v[4:2]});
  endfunction

  function automatic int exp6_of(logic [5:0] v);
    return int'({v, v[5:4]});
  endfunction

  function automatic rrgd_pkg::out_t pixel_predict(int dx, int dy);
    rrgd_pkg::out_t o;
    int c0, c1, r, ins, colh, sx, sy, cdx, rad, arc_sq, d, rv, gv, bv;
    logic [15:0] sc, ec;
    bit solid;
    int tab[64];
    tab = '{0, 32, 8, 40, 2, 34, 10, 42, 48, 16, 56, 24, 50, 18, 58, 26,
            12, 44, 4, 36, 14, 46, 6, 38, 60, 28, 52, 20, 62, 30, 54, 22,
            3, 35, 11, 43, 1, 33, 9, 41, 51, 19, 59, 27, 49, 17, 57, 25,
            15, 47, 7, 39, 13, 45, 5, 37, 63, 31, 55, 23, 61, 29, 53, 21};
    o = '0;
    sc = sh_colors[31:16];
    ec = sh_colors[15:0];
    solid = (sc == ec) || (sh_w == 1);
    if (sh_w <= 0 || sh_h <= 0) return o;
    c0 = (sh_c0 < 0) ? 0 : sh_c0;
    c1 = (sh_c1 > sh_w) ? sh_w : sh_c1;
    if (c0 >= c1 || dx < c0 || dx >= c1) return o;
    r = sh_r;
    if (r > sh_w / 2) r = sh_w / 2;
    if (r > sh_h / 2) r = sh_h / 2;
    // corner inset from the circle
    ins = 0;
    if (!(r <= 0 || (dx >= r && dx < sh_w - r))) begin
      cdx = (dx < r) ? (r - 1 - dx) : (dx - (sh_w - r));
      rad = r - 1;
      arc_sq = rad * rad - cdx * cdx;
      if (arc_sq < 0) arc_sq = 0;
      ins = rad - root_floor(arc_sq);
    end
    colh = sh_h - 2 * ins;
    if (colh <= 0) return o;
    if (!solid && colh > MAX_COL) colh = MAX_COL;
    if (dy < ins || dy >= ins + colh) return o;
    sx = sh_ox + dx;
    sy = sh_oy + dy;
    if (sx < 0 || sx >= SCR_W || sy < 0 || sy >= SCR_H) return o;
    o.drawn = 1'b1;
    o.scr_x = sx[9:0];
    o.scr_y = sy[9:0];
    if (solid) begin
      o.pixel_color = sc;
    end else begin
      d = tab[(sy & 7) * 8 + (sx & 7)];
      rv = channel_mix(exp5_of(sc[15:11]), exp5_of(ec[15:11]), dx, sh_w - 1) + (d >> 3);
      gv = channel_mix(exp6_of(sc[10:5]), exp6_of(ec[10:5]), dx, sh_w - 1) + (d >> 4);
      bv = channel_mix(exp5_of(sc[4:0]), exp5_of(ec[4:0]), dx, sh_w - 1) + (d >> 3);
      if (rv > 255) rv = 255;
      if (gv > 255) gv = 255;
      if (bv > 255) bv = 255;
      o.pixel_color = {rv[7:3], gv[7:2], bv[7:3]};
    end
    return o;
  endfunction

  // result checker and cycle limit
  always @(posedge clk) begin
    rrgd_pkg::out_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL rounded_rect_gradient_dither_top");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        want = pixel_q.pop_front();
        if (want.drawn !== out_data.drawn || want.scr_x !== out_data.scr_x ||
            want.scr_y !== out_data.scr_y ||
            want.pixel_color !== out_data.pixel_color) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", want, out_data);
        end
      end
    end
  end

  task automatic reg_write(logic [rrgd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      rrgd_pkg::REG_ORIGIN_X: sh_ox = sx11(val);
      rrgd_pkg::REG_ORIGIN_Y: sh_oy = sx11(val);
      rrgd_pkg::REG_RECT_WIDTH: sh_w = int'(val[9:0]);
      rrgd_pkg::REG_RECT_HEIGHT: sh_h = int'(val[9:0]);
      rrgd_pkg::REG_CORNER_RADIUS: sh_r = int'(val[8:0]);
      rrgd_pkg::REG_FIRST_COLUMN: sh_c0 = sx11(val);
      rrgd_pkg::REG_COLUMN_LIMIT: sh_c1 = sx11(val);
      default: sh_colors = val;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic shape_setup(int ox, int oy, int w, int h, int r, int c0, int c1,
                             logic [31:0] colors);
    reg_write(rrgd_pkg::REG_ORIGIN_X, ox);
    reg_write(rrgd_pkg::REG_ORIGIN_Y, oy);
    reg_write(rrgd_pkg::REG_RECT_WIDTH, w);
    reg_write(rrgd_pkg::REG_RECT_HEIGHT, h);
    reg_write(rrgd_pkg::REG_CORNER_RADIUS, r);
    reg_write(rrgd_pkg::REG_FIRST_COLUMN, c0);
    reg_write(rrgd_pkg::REG_COLUMN_LIMIT, c1);
    reg_write(rrgd_pkg::REG_GRADIENT_COLORS, colors);
  endtask

  // push one beat at the falling edge, wait for acceptance
  task automatic pixel_send(int col, int row, bit fixed, rrgd_pkg::out_t res);
    if (!quiet && $urandom_range(99) < 11) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_data.column_offset = col[9:0];
    in_data.row_offset = row[9:0];
    do @(posedge clk); while (busy);
    pixel_q.push_back(fixed ? res : pixel_predict(col, row));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  initial begin
    dir_row_t dir_tab[$];
    rrgd_pkg::out_t zero_pix;
    rrgd_pkg::out_t solid_pix;
    int ph, n;
    zero_pix = '0;
    solid_pix = '0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cycles = 0;
    mismatches = 0;
    quiet = 0;
    sh_ox = 0; sh_oy = 0; sh_w = 0; sh_h = 0; sh_r = 0; sh_c0 = 0; sh_c1 = 0;
    sh_colors = '0;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // after reset width is zero: nothing drawn
    pixel_send(0, 0, 1, zero_pix);
    pixel_send(1023, 1023, 1, zero_pix);
    drain();

    // solid rectangle, no corners
    shape_setup(10, 20, 50, 40, 0, 0, 50, 32'hF800F800);
    solid_pix.drawn = 1'b1;
    solid_pix.scr_x = 10'd10;
    solid_pix.scr_y = 10'd20;
    solid_pix.pixel_color = 16'hF800;
    dir_tab = '{
      '{0, 0, 1, solid_pix},
      '{50, 0, 1, zero_pix},
      '{0, 40, 1, zero_pix},
      '{49, 39, 0, zero_pix},
      '{1023, 1023, 1, zero_pix}
    };
    foreach (dir_tab[i]) pixel_send(dir_tab[i].col, dir_tab[i].row, dir_tab[i].fixed,
                                    dir_tab[i].res);
    drain();

    // gradient, clamped radius, negative origin, column range clamps
    shape_setup(-5, -3, 200, 300, 511, -1024, 1023, 32'h0000FFFF);
    dir_tab = '{
      '{0, 150, 0, zero_pix}, '{5, 10, 0, zero_pix}, '{100, 0, 0, zero_pix},
      '{100, 100, 0, zero_pix}, '{199, 150, 0, zero_pix}, '{100, 245, 0, zero_pix},
      '{4, 2, 0, zero_pix}, '{150, 239, 0, zero_pix}, '{60, 60, 0, zero_pix}
    };
    foreach (dir_tab[i]) pixel_send(dir_tab[i].col, dir_tab[i].row, dir_tab[i].fixed,
                                    dir_tab[i].res);
    drain();

    // empty column range, width one, extremes
    shape_setup(1023, -1024, 1, 1023, 3, 1023, -1024, 32'h1234ABCD);
    pixel_send(0, 0, 1, zero_pix);
    drain();
    shape_setup(0, 0, 1, 1023, 0, 0, 1, 32'hFFFF0000);
    pixel_send(0, 319, 0, zero_pix);
    pixel_send(0, 320, 1, zero_pix);
    drain();

    // random phases with random shapes
    for (ph = 0; ph < 32; ph++) begin
      int w, h;
      w = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(1, 260);
      h = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(1, 340);
      shape_setup($urandom_range(9) == 0 ? $urandom : $urandom_range(0, 60) - 30,
                  $urandom_range(9) == 0 ? $urandom : $urandom_range(0, 60) - 30,
                  w, h, $urandom_range(9) < 3 ? $urandom : $urandom_range(0, 60),
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 10) - 5,
                  $urandom_range(3) == 0 ? $urandom : w + $urandom_range(0, 4) - 2,
                  $urandom_range(5) == 0 ? {2{16'($urandom)}} : $urandom);
      quiet = (ph % 8 == 3);
      for (n = 0; n < 50; n++) begin
        if ($urandom_range(9) < 8) pixel_send($urandom_range(w), $urandom_range(h), 0, zero_pix);
        else pixel_send($urandom_range(1023), $urandom_range(1023), 0, zero_pix);
      end
      drain();
    end

    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("PASS rounded_rect_gradient_dither_top");
    end else begin
      $display("FAIL rounded_rect_gradient_dither_top");
    end
    $finish;
  end

endmodule
